[rtl/core/wola_pkg.sv]
// Shared constants, types and the window table for the overlap-add synthesis block.
package wola_pkg;

   // Frame geometry
   localparam int FRAME_SIZE = 512;
   localparam int HOP_SIZE   = 128;
   localparam int EFF_HOP    = (HOP_SIZE < FRAME_SIZE) ? HOP_SIZE : FRAME_SIZE;
   localparam int POS_W      = $clog2(FRAME_SIZE);
   localparam int POSX_W     = POS_W + 1;
   localparam int HALF_SIZE  = (FRAME_SIZE + 1) / 2;
   localparam int WIN_IDX_W  = $clog2(HALF_SIZE);

   // Datapath widths
   localparam int SAMPLE_W = 16;
   localparam int WIN_W    = 16;
   localparam int ACC_W    = 20;
   localparam int MUL_W    = SAMPLE_W + WIN_W + 1;

   typedef logic [POS_W-1:0]           pos_type;
   typedef logic [POSX_W-1:0]          posx_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [WIN_W-1:0]           window_type;
   typedef logic signed [ACC_W-1:0]    acc_type;
   typedef logic [WIN_W-1:0]           window_rom_type [HALF_SIZE];

   localparam pos_type  POS_LAST    = POS_W'(FRAME_SIZE - 1);
   localparam posx_type FRAME_EXT   = POSX_W'(FRAME_SIZE);
   localparam posx_type HOP_EXT     = POSX_W'(EFF_HOP);
   localparam posx_type HOP_LAST    = POSX_W'(EFF_HOP - 1);
   localparam acc_type  ACC_MAX     = acc_type'(524287);
   localparam acc_type  ACC_MIN     = acc_type'(-524288);

   // Item held in the first pipeline stage
   typedef struct packed {
      logic       valid;
      pos_type    slot;
      sample_type sample;
      window_type window;
      logic       emit;
      logic       last;
      logic       fresh;
   } s1_type;

   // Finished sum handed to the output stage
   typedef struct packed {
      logic    push;
      acc_type acc;
      logic    last;
   } res_type;

   // Window table generation (elaboration only)
   localparam longint unsigned PI_Q30   = 64'd3373259426;
   localparam longint unsigned LAST_POS = longint'(FRAME_SIZE - 1);
   localparam longint unsigned TERM_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

   // sin(pi*i/(N-1)) by a Taylor series in Q30, rounded to Q0.16
   function automatic window_type window_value(input int unsigned i);
      longint unsigned m;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      m = (longint'(i) <= LAST_POS - longint'(i)) ? longint'(i) : LAST_POS - longint'(i);
      x = (PI_Q30 * m + LAST_POS / 2) / LAST_POS;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 0; k < 8; k++) begin
         term = ((term * x2) >> 30) / TERM_DIV[k];
         if ((k % 2) == 0)
            sum = sum - longint'(term);
         else
            sum = sum + longint'(term);
      end
      if (sum < 0)
         sum = 0;
      sum = (sum + 8192) >>> 14;
      if (sum > 65535)
         sum = 65535;
      return sum[WIN_W-1:0];
   endfunction

   // Half table: the window is symmetric about the frame centre
   function automatic window_rom_type build_window();
      window_rom_type t;
      for (int i = 0; i < HALF_SIZE; i++)
         t[i] = window_value(i);
      return t;
   endfunction

   localparam window_rom_type WINDOW_ROM = build_window();

endpackage

[rtl/core/weighted_overlap_add_synthesis.sv]
// Top level of the weighted overlap-add synthesis block.
//
//   channel  direction  ports                                    handshake
//   req      in         req_frame_sample                         req_valid / req_ready
//   rsp      out        rsp_out_sample, rsp_hop_last, rsp_clipped rsp_valid / rsp_ready
//
// One item per cycle unless output stalls; the accumulator RAM does one read and one
// write a cycle. A result passes stage one, stage two and then the output register.
// Reset needs no clearing pass: slots read during the first frame count as zero.
// A stalled result holds only the output register; items beyond the hop keep flowing
// until an emitting item reaches the accumulate stage.
module weighted_overlap_add_synthesis
   import wola_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  sample_type req_frame_sample,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output sample_type rsp_out_sample,
   output logic       rsp_hop_last,
   output logic       rsp_clipped
);

   s1_type           s1;
   res_type          res;
   logic             s1_adv;
   logic             rd_en;
   pos_type          rd_addr;
   logic [ACC_W-1:0] rd_data;
   logic             wr_en;
   pos_type          wr_addr;
   logic [ACC_W-1:0] wr_data;
   logic             out_free;

   logic                  rsp_valid_ff, rsp_valid_in;
   sample_type            out_sample_ff;
   logic                  hop_last_ff;
   logic                  clipped_ff;

   logic signed [ACC_W-3:0] q;
   logic signed [ACC_W-2:0] q_rnd;
   logic                    rnd_up;
   logic                    clip;
   sample_type              q_sat;

   wola_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_frame_sample (req_frame_sample),
      .req_ready        (req_ready),
      .s1_adv           (s1_adv),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .s1               (s1)
   );

   wola_ram #(
      .DEPTH (FRAME_SIZE),
      .WIDTH (ACC_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wola_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .s1       (s1),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .out_free (out_free),
      .s1_adv   (s1_adv),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .res      (res)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Q3.17 to Q1.15, round to nearest with ties to even, then saturate
   always_comb begin
      q      = res.acc[ACC_W-1:2];
      rnd_up = res.acc[1] && (res.acc[0] || q[0]);
      q_rnd  = {q[ACC_W-3], q} + (ACC_W-1)'(rnd_up);
      clip   = (q_rnd[ACC_W-2:SAMPLE_W-1] != {(ACC_W-SAMPLE_W){q_rnd[SAMPLE_W-1]}});
      if (clip)
         q_sat = q_rnd[ACC_W-2] ? sample_type'(-32768) : sample_type'(32767);
      else
         q_sat = q_rnd[SAMPLE_W-1:0];
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res.push)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (res.push) begin
         out_sample_ff <= q_sat;
         hop_last_ff   <= res.last;
         clipped_ff    <= clip;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = out_sample_ff;
   assign rsp_hop_last   = hop_last_ff;
   assign rsp_clipped    = clipped_ff;

   // A finished sum never overwrites a result still waiting
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      res.push |-> out_free)
      else $error("result pushed into a full output register");

   // An empty first stage always takes an item
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !s1.valid |-> req_ready)
      else $error("input stalled with an empty pipeline");

   // A clipped output sits at one of the int16 limits
   a_clip_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_out_sample == sample_type'(32767) || rsp_out_sample == sample_type'(-32768)))
      else $error("clipped flag on an unsaturated sample");

endmodule

[rtl/core/wola_ram.sv]
// Simple dual-port RAM, one write and one registered read per cycle.
module wola_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en)
         mem_ff[wr_addr] <= wr_data;
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en)
         rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/wola_front.sv]
// Frame position and ring base tracking, slot addressing and window lookup.
module wola_front
   import wola_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  sample_type req_frame_sample,
   output logic       req_ready,
   input  logic       s1_adv,
   output logic       rd_en,
   output pos_type    rd_addr,
   output s1_type     s1
);

   pos_type  pos_ff, pos_in;
   pos_type  base_ff, base_in;
   logic     primed_ff, primed_in;
   s1_type   s1_ff, s1_in;

   posx_type slot_sum;
   posx_type base_sum;
   pos_type  slot;
   pos_type  mirror;
   pos_type  half_pos;
   logic     accept;
   logic     frame_end;

   assign req_ready = !s1_ff.valid || s1_adv;
   assign accept    = req_valid && req_ready;
   assign frame_end = (pos_ff == POS_LAST);

   // Slot of the current position in the accumulator ring
   always_comb begin
      slot_sum = {1'b0, base_ff} + {1'b0, pos_ff};
      if (slot_sum >= FRAME_EXT)
         slot_sum = slot_sum - FRAME_EXT;
      slot = slot_sum[POS_W-1:0];
   end

   // Fold the position onto the half window table
   always_comb begin
      mirror   = POS_LAST - pos_ff;
      half_pos = (pos_ff <= mirror) ? pos_ff : mirror;
   end

   // Position, ring base and first-frame tracking
   always_comb begin
      pos_in    = pos_ff;
      base_in   = base_ff;
      primed_in = primed_ff;
      base_sum  = {1'b0, base_ff} + HOP_EXT;
      if (base_sum >= FRAME_EXT)
         base_sum = base_sum - FRAME_EXT;
      if (accept) begin
         if (frame_end) begin
            pos_in    = '0;
            base_in   = base_sum[POS_W-1:0];
            primed_in = 1'b1;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   // Stage one contents; slots never written before the first frame ends read as zero
   always_comb begin
      s1_in.valid  = 1'b1;
      s1_in.slot   = slot;
      s1_in.sample = req_frame_sample;
      s1_in.window = WINDOW_ROM[half_pos[WIN_IDX_W-1:0]];
      s1_in.emit   = ({1'b0, pos_ff} < HOP_EXT);
      s1_in.last   = ({1'b0, pos_ff} == HOP_LAST);
      s1_in.fresh  = !primed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         base_ff   <= '0;
         primed_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         base_ff   <= base_in;
         primed_ff <= primed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (accept) begin
         s1_ff <= s1_in;
      end else if (s1_adv) begin
         s1_ff.valid <= 1'b0;
      end
   end

   assign rd_en   = accept;
   assign rd_addr = slot;
   assign s1      = s1_ff;

endmodule

[rtl/core/wola_mac.sv]
// Window multiply, accumulate with saturation and write-back with forwarding.
module wola_mac
   import wola_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  s1_type           s1,
   input  logic             rd_en,
   input  pos_type          rd_addr,
   input  logic [ACC_W-1:0] rd_data,
   input  logic             out_free,
   output logic             s1_adv,
   output logic             wr_en,
   output pos_type          wr_addr,
   output logic [ACC_W-1:0] wr_data,
   output res_type          res
);

   typedef struct packed {
      logic    valid;
      pos_type slot;
      acc_type prod;
      acc_type old;
      logic    emit;
      logic    last;
   } s2_type;

   s2_type  s2_ff, s2_in;
   logic    byp_hit_ff;
   acc_type byp_data_ff;

   logic signed [MUL_W-1:0] mul_full;
   logic signed [MUL_W-1:0] mul_rnd;
   acc_type                 s1_old;
   acc_type                 old_fwd;
   logic signed [ACC_W:0]   sum_wide;
   acc_type                 acc_sat;
   logic                    s2_adv;

   // Flow control: a non-emitting item retires without the output stage
   assign s2_adv = s2_ff.valid && (!s2_ff.emit || out_free);
   assign s1_adv = s1.valid && (!s2_ff.valid || s2_adv);

   // Product rounded from Q1.31 to Q3.17, halves up
   always_comb begin
      mul_full = MUL_W'($signed(s1.sample)) * MUL_W'($signed({1'b0, s1.window}));
      mul_rnd  = mul_full + MUL_W'(8192);
   end

   // Read data, with the write that raced the read and the write during the stall
   always_comb begin
      s1_old  = byp_hit_ff ? byp_data_ff : $signed(rd_data);
      old_fwd = (wr_en && (wr_addr == s1.slot)) ? $signed(wr_data) : s1_old;
   end

   always_comb begin
      s2_in.valid = 1'b1;
      s2_in.slot  = s1.slot;
      s2_in.prod  = acc_type'(mul_rnd >>> 14);
      s2_in.old   = s1.fresh ? '0 : old_fwd;
      s2_in.emit  = s1.emit;
      s2_in.last  = s1.last;
   end

   // Saturating accumulate
   always_comb begin
      sum_wide = {s2_ff.old[ACC_W-1], s2_ff.old} + {s2_ff.prod[ACC_W-1], s2_ff.prod};
      if (sum_wide[ACC_W] != sum_wide[ACC_W-1])
         acc_sat = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
      else
         acc_sat = sum_wide[ACC_W-1:0];
   end

   // Emitted slots go back to zero for the next overlap
   assign wr_en   = s2_adv;
   assign wr_addr = s2_ff.slot;
   assign wr_data = s2_ff.emit ? '0 : acc_sat;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         byp_hit_ff  <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= $signed(wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else if (s1_adv) begin
         s2_ff <= s2_in;
      end else if (s2_adv) begin
         s2_ff.valid <= 1'b0;
      end
   end

   assign res.push = s2_adv && s2_ff.emit;
   assign res.acc  = acc_sat;
   assign res.last = s2_ff.last;

endmodule
